// ===== hdl/qec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qec_pkg: shared types and constants of the quadrature encoder counter
// Holds the channel count, the count width, the request kinds and the
// packed words that travel on the request and response channels.
// ----------------------------------------------------------------------------
package qec_pkg;

   // Number of encoder channels and width of each position count.
   localparam int NUM_CHANNELS = 4;
   localparam int COUNT_BITS   = 16;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_SAMPLE        = 2'd0,
      KIND_READ_COUNT    = 2'd1,
      KIND_READ_VELOCITY = 2'd2,
      KIND_UNUSED        = 2'd3
   } kind_type;

   // One request word.
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  phase_a;
      logic [3:0]  phase_b;
      logic [1:0]  channel;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [15:0]        count;
      logic signed [15:0] velocity;
   } rsp_word_type;

   // Per-channel decode result of one pin sample.
   typedef struct packed {
      logic [NUM_CHANNELS-1:0] up;
      logic [NUM_CHANNELS-1:0] down;
      logic [NUM_CHANNELS-1:0] next_a;
      logic [NUM_CHANNELS-1:0] next_b;
   } qec_step_type;

endpackage
`default_nettype wire

// ===== hdl/qec_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qec_decode: x4 quadrature edge decoder for all channels
// Compares a pin sample with the previous levels and tells, per channel,
// whether the count goes up, goes down, and which levels are kept.
// ----------------------------------------------------------------------------
module qec_decode
   import qec_pkg::*;
(
   input  wire logic [NUM_CHANNELS-1:0] enable,
   input  wire logic [NUM_CHANNELS-1:0] phase_a,
   input  wire logic [NUM_CHANNELS-1:0] phase_b,
   input  wire logic [NUM_CHANNELS-1:0] prev_a,
   input  wire logic [NUM_CHANNELS-1:0] prev_b,
   output qec_step_type                 step
);

   // Each channel is decoded on its own. An A edge takes priority over a
   // B edge; a disabled channel neither counts nor updates its levels.
   always_comb begin
      logic a_edge;
      logic b_edge;
      logic dir_up;
      step = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         a_edge = phase_a[ch] ^ prev_a[ch];
         b_edge = phase_b[ch] ^ prev_b[ch];
         dir_up = a_edge ? (phase_a[ch] != phase_b[ch]) : (phase_a[ch] == phase_b[ch]);
         if (enable[ch]) begin
            step.up[ch]     = (a_edge || b_edge) && dir_up;
            step.down[ch]   = (a_edge || b_edge) && !dir_up;
            step.next_a[ch] = phase_a[ch];
            step.next_b[ch] = phase_b[ch];
         end else begin
            step.next_a[ch] = prev_a[ch];
            step.next_b[ch] = prev_b[ch];
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/quad_encoder_counter_4ch_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quad_encoder_counter_4ch_top: four-channel x4 quadrature encoder counter
// Decodes pin samples into wrapping position counts and answers count and
// velocity reads with one response word each.
// ----------------------------------------------------------------------------
//  Channel    Ports                           Direction
//  request    req_valid, req_stall, req_word  in  (pin sample or read)
//  response   rsp_valid, rsp_stall, rsp_word  out (count and velocity)
//  csr        csr_write, csr_data             in  (channel enable)
//
// A word is taken into an input register, then decoded and applied to the
// counts as it moves on, where a read loads the response register.
// One word is accepted every cycle while the input register does not hold.
// The input register only holds while a read waits on a stalled response.
// Reset clears all counts, held levels and the channel enable.
// ----------------------------------------------------------------------------
module quad_encoder_counter_4ch_top
   import qec_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write,
   input  wire logic [3:0]   csr_data
);

   // Input register and response register.
   logic                    s1_valid_ff,  s1_valid_in;
   req_word_type            s1_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff,  rsp_word_in;

   // Block state.
   logic [3:0]              enable_ff;
   logic [NUM_CHANNELS-1:0] prev_a_ff,    prev_a_in;
   logic [NUM_CHANNELS-1:0] prev_b_ff,    prev_b_in;
   logic [COUNT_BITS-1:0]   position_ff   [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]   position_in   [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]   last_read_ff  [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]   last_read_in  [NUM_CHANNELS];

   logic                    is_read;
   logic                    s1_advance;
   logic                    req_accept;
   qec_step_type            step;

   // Edge decode of the registered sample.
   qec_decode u_decode (
      .enable  (enable_ff[NUM_CHANNELS-1:0]),
      .phase_a (s1_word_ff.phase_a[NUM_CHANNELS-1:0]),
      .phase_b (s1_word_ff.phase_b[NUM_CHANNELS-1:0]),
      .prev_a  (prev_a_ff),
      .prev_b  (prev_b_ff),
      .step    (step)
   );

   // Handshake: a read moves on only when the response register is free.
   always_comb begin
      is_read    = (s1_word_ff.kind == KIND_READ_COUNT) ||
                   (s1_word_ff.kind == KIND_READ_VELOCITY);
      s1_advance = s1_valid_ff && (!is_read || !rsp_valid_ff || !rsp_stall);
      req_stall  = s1_valid_ff && !s1_advance;
      req_accept = req_valid && !req_stall;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
   end

   // Next state of the counts and the response word.
   always_comb begin
      logic [COUNT_BITS-1:0] pos;
      logic [COUNT_BITS-1:0] diff;
      prev_a_in    = prev_a_ff;
      prev_b_in    = prev_b_ff;
      position_in  = position_ff;
      last_read_in = last_read_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pos  = position_ff[s1_word_ff.channel];
      diff = pos - last_read_ff[s1_word_ff.channel];
      if (s1_advance) begin
         case (s1_word_ff.kind)
            KIND_SAMPLE: begin
               prev_a_in = step.next_a;
               prev_b_in = step.next_b;
               for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                  if (step.up[ch]) begin
                     position_in[ch] = position_ff[ch] + COUNT_BITS'(1);
                  end else if (step.down[ch]) begin
                     position_in[ch] = position_ff[ch] - COUNT_BITS'(1);
                  end
               end
            end
            KIND_READ_COUNT, KIND_READ_VELOCITY: begin
               rsp_valid_in = 1'b1;
               if (32'(s1_word_ff.channel) < NUM_CHANNELS) begin
                  rsp_word_in.count    = 16'(pos);
                  rsp_word_in.velocity = '0;
                  if (s1_word_ff.kind == KIND_READ_VELOCITY) begin
                     rsp_word_in.velocity = signed'(16'(diff));
                     last_read_in[s1_word_ff.channel] = pos;
                  end
               end else begin
                  rsp_word_in = '0;
               end
            end
            default: begin
               // Unused kind: dropped without effect.
            end
         endcase
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= '0;
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            position_ff[ch]  <= '0;
            last_read_ff[ch] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_a_ff    <= prev_a_in;
         prev_b_ff    <= prev_b_in;
         position_ff  <= position_in;
         last_read_ff <= last_read_in;
         if (csr_write) begin
            enable_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the four-channel quadrature counter
// Drives pin samples and count/velocity reads through the request channel,
// tracks the expected positions and velocities alongside the block, and
// checks every response word against the oldest expected word. Both sides
// idle in random bursts, and one long response stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
   import qec_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 300;

   // Clock, reset and the ports of the block.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write = 1'b0;
   logic [3:0]   csr_data = 4'd0;

   // Expected response words, oldest first.
   rsp_word_type expected_rsp[$];

   // Tracked state of the encoder counter.
   logic [3:0]            enable_mask;
   logic [3:0]            held_a;
   logic [3:0]            held_b;
   logic [COUNT_BITS-1:0] position[NUM_CHANNELS];
   logic [COUNT_BITS-1:0] velocity_base[NUM_CHANNELS];

   // Pin levels that the stimulus walks through.
   logic [3:0] pin_a = 4'd0;
   logic [3:0] pin_b = 4'd0;

   // Idling controls and bookkeeping.
   bit sender_gaps = 1'b0;
   bit receiver_gaps = 1'b0;
   bit long_hold_armed = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int cycles = 0;
   int errors = 0;
   int words_sent = 0;
   int samples_sent = 0;
   int reads_sent = 0;
   int results_checked = 0;
   int mask_writes = 0;

   quad_encoder_counter_4ch_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d words still expected",
                  $time, expected_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response side: one long hold when armed, otherwise random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_armed || hold_left > 0) begin
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted response word with the oldest expected word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response word, count %0d velocity %0d",
                     $time, rsp_word.count, rsp_word.velocity);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.count !== want.count) begin
               $display("%0t: count mismatch, expected %0d, actual %0d",
                        $time, want.count, rsp_word.count);
               errors++;
            end
            if (rsp_word.velocity !== want.velocity) begin
               $display("%0t: velocity mismatch, expected %0d, actual %0d",
                        $time, want.velocity, rsp_word.velocity);
               errors++;
            end
            results_checked++;
         end
      end
   end

   // Apply one accepted word to the tracked state and queue its response.
   task automatic track_encoder_word(input req_word_type w);
      rsp_word_type r;
      logic a_now;
      logic b_now;
      logic a_edge;
      logic b_edge;
      r = '0;
      case (w.kind)
         KIND_SAMPLE: begin
            samples_sent++;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
               if (enable_mask[ch]) begin
                  a_now  = w.phase_a[ch];
                  b_now  = w.phase_b[ch];
                  a_edge = a_now != held_a[ch];
                  b_edge = b_now != held_b[ch];
                  // An A edge decides the direction even when B moved too.
                  if (a_edge || b_edge) begin
                     if (a_edge ? (a_now != b_now) : (a_now == b_now))
                        position[ch] = position[ch] + 1'b1;
                     else
                        position[ch] = position[ch] - 1'b1;
                  end
                  held_a[ch] = a_now;
                  held_b[ch] = b_now;
               end
            end
         end
         KIND_READ_COUNT, KIND_READ_VELOCITY: begin
            reads_sent++;
            if (w.channel < NUM_CHANNELS) begin
               r.count = position[w.channel];
               if (w.kind == KIND_READ_VELOCITY) begin
                  r.velocity = position[w.channel] - velocity_base[w.channel];
                  velocity_base[w.channel] = position[w.channel];
               end
            end
            expected_rsp.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   // Offer one word, with an optional idle burst first, until it is taken.
   task automatic send_word(input req_word_type w);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_encoder_word(w);
      words_sent++;
   endtask

   // Stop offering and let every expected word and the pipeline drain.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_channel_enable(input logic [3:0] mask);
      wait_until_idle();
      csr_data  <= mask;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      enable_mask = mask;
      mask_writes++;
   endtask

   function automatic req_word_type make_word(input kind_type k, input logic [3:0] a,
                                              input logic [3:0] b, input logic [1:0] ch);
      req_word_type w;
      w.kind    = k;
      w.phase_a = a;
      w.phase_b = b;
      w.channel = ch;
      return w;
   endfunction

   // Next pin sample: each channel holds, steps either way, or jumps both
   // phases; a noisy sample replaces all levels at random.
   function automatic req_word_type make_sample(input bit noisy);
      if (noisy) begin
         pin_a = 4'($urandom);
         pin_b = 4'($urandom);
      end else begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            case ($urandom_range(0, 6))
               0, 1: begin
               end
               2, 3: begin
                  if (pin_a[ch] == pin_b[ch]) pin_a[ch] = ~pin_a[ch];
                  else pin_b[ch] = ~pin_b[ch];
               end
               4, 5: begin
                  if (pin_a[ch] == pin_b[ch]) pin_b[ch] = ~pin_b[ch];
                  else pin_a[ch] = ~pin_a[ch];
               end
               default: begin
                  pin_a[ch] = ~pin_a[ch];
                  pin_b[ch] = ~pin_b[ch];
               end
            endcase
         end
      end
      return make_word(KIND_SAMPLE, pin_a, pin_b, 2'($urandom));
   endfunction

   function automatic req_word_type make_random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return make_sample(1'b0);
      else if (pick < 70)
         return make_sample(1'b1);
      else if (pick < 82)
         return make_word(KIND_READ_COUNT, 4'($urandom), 4'($urandom), 2'($urandom));
      else if (pick < 95)
         return make_word(KIND_READ_VELOCITY, 4'($urandom), 4'($urandom), 2'($urandom));
      else
         return make_word(KIND_UNUSED, 4'($urandom), 4'($urandom), 2'($urandom));
   endfunction

   // Reads after reset, wrap below zero and back, simultaneous phase
   // changes, repeated levels and the unused kind.
   task automatic test_directed_edges();
      write_channel_enable(4'hF);
      send_word(make_word(KIND_READ_COUNT, 4'h0, 4'h0, 2'd0));
      send_word(make_word(KIND_READ_VELOCITY, 4'hF, 4'hF, 2'd3));
      send_word(make_word(KIND_SAMPLE, 4'h0, 4'hF, 2'd0));
      send_word(make_word(KIND_READ_COUNT, 4'h0, 4'h0, 2'd2));
      send_word(make_word(KIND_READ_VELOCITY, 4'h0, 4'h0, 2'd2));
      send_word(make_word(KIND_SAMPLE, 4'hF, 4'hF, 2'd3));
      send_word(make_word(KIND_SAMPLE, 4'hF, 4'h0, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'h0, 4'hF, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'h0, 4'hF, 2'd0));
      send_word(make_word(KIND_UNUSED, 4'hF, 4'hF, 2'd3));
      send_word(make_word(KIND_SAMPLE, 4'h0, 4'h0, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'hF, 4'h0, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'hF, 4'hF, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'h0, 4'hF, 2'd0));
      send_word(make_word(KIND_SAMPLE, 4'h5, 4'h3, 2'd0));
      for (int ch = 0; ch < NUM_CHANNELS; ch++)
         send_word(make_word(KIND_READ_VELOCITY, 4'h0, 4'h0, 2'(ch)));
      send_word(make_word(KIND_READ_COUNT, 4'h0, 4'h0, 2'd1));
      pin_a = 4'h5;
      pin_b = 4'h3;
   endtask

   // Disabled channels hold their counts and levels; re-enabled ones
   // compare the next sample with the held levels.
   task automatic test_channel_enable();
      logic [3:0] masks[4];
      masks = '{4'h0, 4'h5, 4'hA, 4'hF};
      foreach (masks[m]) begin
         write_channel_enable(masks[m]);
         repeat (6) send_word(make_sample($urandom_range(0, 3) == 0));
         for (int ch = 0; ch < NUM_CHANNELS; ch++)
            send_word(make_word(KIND_READ_VELOCITY, 4'($urandom), 4'($urandom), 2'(ch)));
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         write_channel_enable(phase == 0 ? 4'hF : 4'($urandom));
         repeat (60) send_word(make_random_word());
      end
   endtask

   // A long response stall while words keep coming fills the block.
   task automatic test_response_backpressure();
      write_channel_enable(4'hF);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      long_hold_armed = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0)
            send_word(make_sample(1'b0));
         else
            send_word(make_word(KIND_READ_VELOCITY, 4'($urandom), 4'($urandom),
                                2'($urandom)));
      end
      wait_until_idle();
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // Back-to-back traffic at full rate with no idling on either side.
   task automatic test_full_rate();
      write_channel_enable(4'($urandom));
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (60) send_word(make_random_word());
   endtask

   initial begin
      enable_mask = 4'd0;
      held_a = 4'd0;
      held_b = 4'd0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         position[ch] = '0;
         velocity_base[ch] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      test_directed_edges();
      test_channel_enable();
      test_random_traffic();
      test_response_backpressure();
      test_full_rate();
      wait_until_idle();

      $display("Covered %0d words: %0d pin samples, %0d reads, %0d enable writes.",
               words_sent, samples_sent, reads_sent, mask_writes);
      $display("Checked %0d response words with %0d mismatches.",
               results_checked, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
